/* rtl/skt_pkg.sv */
// Shared types and codes for the sorted key table.
package skt_pkg;

  localparam int SKT_CAPACITY  = 64;
  localparam int SKT_KEY_WIDTH = 32;

  localparam logic [2:0] OP_INSERT          = 3'd0;
  localparam logic [2:0] OP_REMOVE_ONE      = 3'd1;
  localparam logic [2:0] OP_REMOVE_ALL      = 3'd2;
  localparam logic [2:0] OP_REMOVE_SMALLEST = 3'd3;
  localparam logic [2:0] OP_QUERY           = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic load_req; // capture operation and key
    logic exec;     // apply the request and load the result register
    logic step;     // remove the first equal key, no result
    logic finish;   // load the result of a finished remove-all
  } skt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic present; // request key is in the table
    logic sweep;   // remove-all with at least one match
  } skt_stat_t;

endpackage

/* rtl/skt_datapath.sv */
// Key cells, entry count, request and result registers of the sorted key table.
module skt_datapath
  import skt_pkg::*;
#(
  parameter int CAPACITY  = SKT_CAPACITY,
  parameter int KEY_WIDTH = SKT_KEY_WIDTH,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  skt_cmd_t                    cmd,
  output skt_stat_t                   stat,
  input  logic [2:0]                  operation,
  input  logic signed [KEY_WIDTH-1:0] key,
  output logic                        found,
  output logic [CNT_W-1:0]            count,
  output logic [1:0]                  status
);

  logic [2:0]                  op_r;
  logic signed [KEY_WIDTH-1:0] key_r;
  logic signed [KEY_WIDTH-1:0] cells [CAPACITY];
  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            cnt_next;

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] le;   // cell is at or past the insert point (or unused)
  logic [CAPACITY-1:0] eq;
  logic                present;
  logic                full;
  logic                empty;

  logic       ex_found;
  logic [1:0] ex_status;
  logic       ins_ok;
  logic       del_ok;
  logic       dec_ok;
  logic       do_ins;
  logic       do_del;
  logic       do_dec;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= operation;
      key_r <= key;
    end
  end

  // One compare-and-shift cell per entry. Stored keys are descending, so
  // le is monotone: false up to the insert point, true from there on.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] prev_c;
    logic signed [KEY_WIDTH-1:0] next_c;
    logic                        prev_le;

    assign valid[i] = CNT_W'(i) < cnt;
    assign le[i]    = !valid[i] || (key_r >= cells[i]);
    assign eq[i]    = valid[i] && (cells[i] == key_r);

    if (i == 0) begin : g_first
      assign prev_le = 1'b0;
      assign prev_c  = key_r;
    end else begin : g_mid
      assign prev_le = le[i-1];
      assign prev_c  = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_c = cells[i];
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    always_ff @(posedge clk) begin
      if (do_ins && le[i]) begin
        cells[i] <= prev_le ? prev_c : key_r;
      end else if (do_del && le[i]) begin
        // first le cell is the first equal key when present
        cells[i] <= next_c;
      end
    end
  end

  assign present = |eq;
  assign full    = cnt == CNT_W'(CAPACITY);
  assign empty   = cnt == '0;

  always_comb begin
    ex_found  = present;
    ex_status = ST_OK;
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    dec_ok    = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        if (full) ex_status = ST_FULL;
        else      ins_ok    = 1'b1;
      end
      OP_REMOVE_ONE, OP_REMOVE_ALL: begin
        if (empty)         ex_status = ST_EMPTY;
        else if (!present) ex_status = ST_NOT_FOUND;
        else               del_ok    = 1'b1;
      end
      OP_REMOVE_SMALLEST: begin
        ex_found = 1'b0;
        if (empty) ex_status = ST_EMPTY;
        else       dec_ok    = 1'b1;
      end
      default: begin
        if (!present) ex_status = ST_NOT_FOUND;
      end
    endcase
  end

  assign do_ins = cmd.exec && ins_ok;
  assign do_del = (cmd.exec && del_ok) || cmd.step;
  assign do_dec = do_del || (cmd.exec && dec_ok);

  always_comb begin
    priority if (do_ins) cnt_next = cnt + CNT_W'(1);
    else if (do_dec)     cnt_next = cnt - CNT_W'(1);
    else                 cnt_next = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      found  <= ex_found;
      status <= ex_status;
      count  <= cnt_next;
    end else if (cmd.finish) begin
      found  <= 1'b1;
      status <= ST_OK;
      count  <= cnt;
    end
  end

  assign stat.present = present;
  assign stat.sweep   = (op_r == OP_REMOVE_ALL) && present;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_step_decrements: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("sweep step did not drop one key");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    cnt >= CNT_W'(2) |-> cells[0] >= cells[1])
    else $error("table head out of order");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.finish) |=> count == cnt)
    else $error("reported count differs from table");

endmodule

/* rtl/skt_ctrl.sv */
// Request sequencer and result handshake of the sorted key table.
module skt_ctrl
  import skt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      res_valid,
  input  logic      res_ready,
  input  skt_stat_t stat,
  output skt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   res_valid_next;

  assign slot_free = !res_valid || res_ready;
  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.sweep) begin
          cmd.step   = 1'b1;
          state_next = S_SWEEP;
        end else if (slot_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (stat.present) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res_valid_next = (res_valid && !res_ready) || cmd.exec || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

/* rtl/sorted_key_table.sv */
// Top level of the sorted key table: controller plus key cell datapath.
//
// Holds up to CAPACITY signed keys in descending order, duplicates allowed.
// Request channel (req_valid/req_ready): operation and key. Codes: insert,
// remove first equal, remove all equal, remove smallest, query; the unused
// codes act as query. Result channel (res_valid/res_ready): found, count
// and status, exactly one result per request, in request order.
// Timing: a request is captured at the accepting edge, then compared
// against every stored key at once in the exec state. Except for a remove-all
// with a match, the table is updated and the result register loaded there
// once the output register is free; res_valid rises with that load. The next
// request is taken only once the sequencer is back in idle. Remove-all drops
// one matching key per cycle, without waiting for the output register, then
// loads its result when the output register is free. The single search-and-shift step over the cell row sets that rate.
// Only one request is in flight; req_ready is high while the sequencer is
// idle, even with an untaken result waiting in the output register.
// If the receiver stalls, a finished request waits in its last cycle (exec,
// or the end of a remove-all sweep) and the table is not touched again
// until the output register frees up.
// Reset (rst, synchronous) empties the table; res_valid drops.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY  = SKT_CAPACITY,
  parameter int KEY_WIDTH = SKT_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic [2:0]                       operation,
  input  logic signed [KEY_WIDTH-1:0]      key,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic                             found,
  output logic [$clog2(CAPACITY + 1)-1:0]  count,
  output logic [1:0]                       status
);

  skt_cmd_t  cmd;
  skt_stat_t stat;

  // sequencer: accept, execute, optional remove-all sweep
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // cell row, entry count and result register
  skt_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     ($clog2(CAPACITY + 1))
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .key       (key),
    .found     (found),
    .count     (count),
    .status    (status)
  );

endmodule

/* verif/key_table_tracker_pkg.sv */
// Scoreboard class for the sorted key table: table model and expected results.
package key_table_tracker_pkg;
  import skt_pkg::*;

  localparam int COUNT_W = $clog2(SKT_CAPACITY + 1);

  typedef logic signed [SKT_KEY_WIDTH-1:0] table_key_t;

  typedef struct {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } table_result_t;

  class table_tracker;
    table_key_t    keys[$];        // stored keys, largest first
    table_result_t expected_q[$];  // outcomes still to come, oldest first
    int            errors;

    function int pending();
      return expected_q.size();
    endfunction

    function table_key_t pick_stored();
      if (keys.size() == 0) begin
        return '0;
      end
      return keys[$urandom_range(0, keys.size() - 1)];
    endfunction

    // Apply one accepted request to the table and queue its outcome.
    function void note_request(logic [2:0] op, table_key_t k);
      table_result_t want;
      bit            hit;
      int            pos;
      int            idx;
      hit = 1'b0;
      foreach (keys[i]) begin
        if (keys[i] == k) begin
          hit = 1'b1;
        end
      end
      want.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (keys.size() >= SKT_CAPACITY) begin
            want.status = ST_FULL;
          end else begin
            // new key goes ahead of the first key not greater than it
            pos = keys.size();
            for (int i = 0; i < keys.size(); i++) begin
              if (k >= keys[i]) begin
                pos = i;
                break;
              end
            end
            keys.insert(pos, k);
          end
        end
        OP_REMOVE_ONE, OP_REMOVE_ALL: begin
          if (keys.size() == 0) begin
            want.status = ST_EMPTY;
          end else if (!hit) begin
            want.status = ST_NOT_FOUND;
          end else begin
            idx = 0;
            while (idx < keys.size()) begin
              if (keys[idx] == k) begin
                keys.delete(idx);
                if (op == OP_REMOVE_ONE) begin
                  break;
                end
              end else begin
                idx++;
              end
            end
          end
        end
        OP_REMOVE_SMALLEST: begin
          hit = 1'b0;
          if (keys.size() == 0) begin
            want.status = ST_EMPTY;
          end else begin
            void'(keys.pop_back());
          end
        end
        default: begin
          // query, and the unused codes that act as query
          if (!hit) begin
            want.status = ST_NOT_FOUND;
          end
        end
      endcase
      want.found = hit;
      want.count = COUNT_W'(keys.size());
      expected_q.push_back(want);
    endfunction

    function void check_result(logic f, logic [COUNT_W-1:0] c, logic [1:0] s);
      table_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: found=%0d count=%0d status=%0d", f, c, s);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (f !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, f);
        errors++;
      end
      if (c !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, c);
        errors++;
      end
      if (s !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, s);
        errors++;
      end
    endfunction
  endclass

endpackage

/* verif/sorted_key_table_test.sv */
// Testbench top for the sorted key table: stimulus, result sink and checks.
module sorted_key_table_test;
  import skt_pkg::*;
  import key_table_tracker_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes 5..7 are unused and must behave as query.
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  localparam table_key_t KEY_MAX = {1'b0, {(SKT_KEY_WIDTH - 1){1'b1}}};
  localparam table_key_t KEY_MIN = {1'b1, {(SKT_KEY_WIDTH - 1){1'b0}}};

  localparam int RANDOM_ITEMS   = 1000;
  localparam int QUIET_ITEMS    = 150;   // tail of the run with no idling at all
  localparam int TAIL_CYCLES    = 16;
  // Longest legal silence is a remove-all over a full table plus stalls;
  // this is many times that.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [2:0]         operation = OP_QUERY;
  table_key_t         key       = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic               found;
  logic [COUNT_W-1:0] count;
  logic [1:0]         status;

  table_tracker tracker = new();
  bit           no_idle = 1'b0;
  int           quiet_cycles = 0;

  sorted_key_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .operation (operation),
    .key       (key),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .found     (found),
    .count     (count),
    .status    (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Present one request, optionally after a short idle burst, and hold it
  // until the block takes it. The model is updated at the accepting edge so
  // expectations stay in request order.
  task automatic send_request(input logic [2:0] op, input table_key_t k);
    int gap;
    gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    key       <= k;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    tracker.note_request(op, k);
  endtask

  // Operation mix per phase: fill pushes the table to full (and past it),
  // drain walks it back to empty, mixed stirs everything including the
  // unused codes.
  function automatic logic [2:0] pick_op(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 80) return OP_INSERT;
        if (r < 85) return OP_QUERY;
        if (r < 90) return OP_REMOVE_ONE;
        if (r < 95) return OP_REMOVE_ALL;
        return OP_REMOVE_SMALLEST;
      end
      PH_DRAIN: begin
        if (r < 10) return OP_INSERT;
        if (r < 40) return OP_REMOVE_SMALLEST;
        if (r < 65) return OP_REMOVE_ONE;
        if (r < 85) return OP_REMOVE_ALL;
        if (r < 95) return OP_QUERY;
        return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      default: begin
        if (r < 35) return OP_INSERT;
        if (r < 50) return OP_REMOVE_ONE;
        if (r < 60) return OP_REMOVE_ALL;
        if (r < 70) return OP_REMOVE_SMALLEST;
        if (r < 90) return OP_QUERY;
        return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
    endcase
  endfunction

  // Keys: a small window around zero makes duplicates and hits likely,
  // stored keys make removals land, extremes and full-range values cover
  // every bit and the signed ordering.
  function automatic table_key_t pick_key(int span);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = int'($urandom_range(0, 2 * span)) - span;
      return table_key_t'(v);
    end
    if (r < 70) return tracker.pick_stored();
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MAX;
        1:       return KEY_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return table_key_t'($urandom);
  endfunction

  // Result side: random stall bursts, none in the tail.
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  // Results are taken at the same edge the block sees them accepted.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      tracker.check_result(found, count, status);
    end
  end

  // Watchdog: any handshake on either side resets the silence counter.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    phase_t ph;
    int     sent;
    int     len;
    int     span;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table corner cases first.
    send_request(OP_REMOVE_ONE, table_key_t'(5));
    send_request(OP_REMOVE_ALL, table_key_t'(5));
    send_request(OP_REMOVE_SMALLEST, KEY_MAX);
    send_request(OP_QUERY, '0);
    // Extremes and signed ordering, plus a duplicate.
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, '1);
    send_request(OP_INSERT, '0);
    send_request(OP_QUERY, KEY_MAX);
    send_request(OP_QUERY, KEY_MIN);
    // Unused codes behave as query, hit and miss.
    send_request(OP_UNUSED_LO, '1);
    send_request(OP_UNUSED_MID, table_key_t'(12345));
    send_request(OP_UNUSED_HI, '0);
    // Removals: first equal, absent key, all equal, smallest.
    send_request(OP_REMOVE_ONE, '0);
    send_request(OP_REMOVE_ONE, table_key_t'(77));
    send_request(OP_REMOVE_ALL, table_key_t'(-77));
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, '0);
    send_request(OP_REMOVE_ALL, '0);
    send_request(OP_REMOVE_SMALLEST, '0);
    send_request(OP_REMOVE_ALL, KEY_MAX);
    // Removal of the single remaining entry.
    send_request(OP_REMOVE_ONE, '1);
    send_request(OP_QUERY, '1);

    // Random phases; the narrow key window gives long runs of duplicates
    // so remove-all has many matches to sweep.
    sent = 0;
    ph   = PH_FILL;
    while (sent < RANDOM_ITEMS) begin
      span = $urandom_range(0, 1) ? 3 : 40;
      len  = (ph == PH_FILL) ? $urandom_range(100, 160) : $urandom_range(60, 120);
      for (int n = 0; n < len && sent < RANDOM_ITEMS; n++) begin
        no_idle = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
        send_request(pick_op(ph), pick_key(span));
        sent++;
      end
      case (ph)
        PH_FILL:  ph = PH_MIXED;
        PH_MIXED: ph = PH_DRAIN;
        default:  ph = PH_FILL;
      endcase
    end
    req_valid <= 1'b0;

    // Drain outstanding results; the watchdog bounds this wait.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sorted_key_table.f */
rtl/skt_pkg.sv
rtl/skt_datapath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table.sv
verif/key_table_tracker_pkg.sv
verif/sorted_key_table_test.sv
